// ===== rtl/core/tpzr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpzr_pkg: shared types and constants
// Fixed-point constants, CORDIC arctangent table and cell data type for the
// time-phased Z pose rotator.
// ----------------------------------------------------------------------------
package tpzr_pkg;

	localparam int CORDIC_STEPS = 24;

	// configuration register indexes
	localparam logic REG_SPIN_RPM     = 1'b0;
	localparam logic REG_START_OFFSET = 1'b1;

	// point status codes
	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_NEG = 2'd1;
	localparam logic [1:0] STATUS_DEC = 2'd2;

	localparam logic [31:0] MINUS_ONE_SEC = 32'hFFFF_0000;
	localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
	// (2^32 - 1) / 15: 2^32 = 15 * K_DIV15 + 1
	localparam logic [31:0] K_DIV15 = 32'd286331153;
	// 15 * 2^31 keeps the divide-by-15 dividend non-negative
	localparam logic [35:0] DIV_BIAS = 36'd32212254720;
	// ceil(2^36 / 15) = 0x1_1111_1112, split in low 16 and high 17 bits;
	// exact floor(v / 15) as (v * recip) >> 36 for v below 2^36 / 14
	localparam logic [15:0] RECIP15_LO = 16'h1112;
	localparam logic [16:0] RECIP15_HI = 17'h1_1111;
	localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;

	typedef struct packed {
		logic              vld;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cordic_vec_t;

	typedef logic [3:0][31:0] word4_t;
	typedef logic [7:0][31:0] word8_t;

	// arctangent of 2^-i in units of 2^-32 turn, rounded
	function automatic logic [29:0] atan_lut(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			5'd31: v = 30'd0;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// clamp to [-1, 1] in Q2.30
	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30) r = 32'sd1073741824;
		else if (v < -ONE_Q30) r = -32'sd1073741824;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/tpzr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tpzr_cordic_cell: one CORDIC rotation step
// Registered micro-rotation by atan(2^-step); cells chain into the full CORDIC.
// ----------------------------------------------------------------------------
module tpzr_cordic_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [4:0]            step,
	input  tpzr_pkg::cordic_vec_t din,
	output tpzr_pkg::cordic_vec_t dout
);
	import tpzr_pkg::*;

	logic               vld_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] dx, dy, ang;

	assign dx  = din.y >>> step;
	assign dy  = din.x >>> step;
	assign ang = $signed({4'b0000, atan_lut(step)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else vld_q <= din.vld;
	end

	always_ff @(posedge clk) begin
		if (din.vld) begin
			if (!din.z[33]) begin
				x_q <= din.x - dx;
				y_q <= din.y + dy;
				z_q <= din.z - ang;
			end else begin
				x_q <= din.x + dx;
				y_q <= din.y - dy;
				z_q <= din.z + ang;
			end
		end
	end

	assign dout = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== rtl/core/tpzr_phase.sv =====
// ----------------------------------------------------------------------------
// tpzr_phase: binary angle of the spin
// phase = floor(rpm * sum / 60) mod 2^32, via two partial products, a fold
// modulo 2^32 and a reciprocal multiply for the divide by 15.
// ----------------------------------------------------------------------------
module tpzr_phase (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  rpm,
	input  logic signed [33:0]  sum,
	output logic                done,
	output logic [31:0]         phase
);
	import tpzr_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_MLO, P_MHI, P_ADD, P_HK, P_FOLD, P_QLO, P_QHI, P_FIN
	} pstate_t;

	pstate_t            state_q;
	logic               done_q;
	logic signed [49:0] plo_q;
	logic signed [48:0] phi_q;
	logic [31:0]        h_q, l_q, hk_q, phase_q;
	logic [35:0]        div_q;
	logic [32:0]        fold_q;
	logic [48:0]        qlo_q;
	logic [49:0]        qhi_q;
	logic signed [65:0] pfull;
	logic [65:0]        qsum;

	assign pfull = ($signed({{17{phi_q[48]}}, phi_q}) <<< 17) + $signed({{16{plo_q[49]}}, plo_q});
	// fold_q * ceil(2^36 / 15); quotient in bits 65:36
	assign qsum  = {qhi_q, 16'd0} + {17'd0, qlo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == P_FIN);
			unique case (state_q)
				P_IDLE: if (start) state_q <= P_MLO;
				P_MLO:  state_q <= P_MHI;
				P_MHI:  state_q <= P_ADD;
				P_ADD:  state_q <= P_HK;
				P_HK:   state_q <= P_FOLD;
				P_FOLD: state_q <= P_QLO;
				P_QLO:  state_q <= P_QHI;
				P_QHI:  state_q <= P_FIN;
				P_FIN:  state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			P_MLO: plo_q <= rpm * $signed({1'b0, sum[16:0]});
			P_MHI: phi_q <= rpm * $signed(sum[33:17]);
			P_ADD: begin
				h_q <= pfull[65:34];
				l_q <= pfull[33:2];
			end
			P_HK: begin
				hk_q  <= 32'(h_q * K_DIV15);
				div_q <= {{4{h_q[31]}}, h_q} + {4'b0000, l_q} + DIV_BIAS;
			end
			// 2^32 = 1 mod 15: fold the top nibble back into the low word
			P_FOLD: begin
				hk_q   <= hk_q + 32'(div_q[35:32] * K_DIV15);
				fold_q <= {1'b0, div_q[31:0]} + 33'(div_q[35:32]);
			end
			P_QLO: qlo_q <= fold_q * RECIP15_LO;
			P_QHI: qhi_q <= fold_q * RECIP15_HI;
			P_FIN: phase_q <= hk_q + {2'b00, qsum[65:36]} + 32'h8000_0000;
			default: ;
		endcase
	end

	assign done  = done_q;
	assign phase = phase_q;

endmodule

// ===== rtl/core/tpzr_rotate.sv =====
// ----------------------------------------------------------------------------
// tpzr_rotate: Z rotation of two pose rows
// One shared multiplier, two products per output, round and saturate;
// results shift through a row of eight result registers.
// ----------------------------------------------------------------------------
module tpzr_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] c,
	input  logic signed [31:0] s,
	input  tpzr_pkg::word4_t   a,
	input  tpzr_pkg::word4_t   b,
	output logic               done,
	output tpzr_pkg::word8_t   res
);
	import tpzr_pkg::*;

	logic               run_q, vld_s1, done_q;
	logic [3:0]         k_q, k_s1;
	logic signed [63:0] prod_s1, acc_q, total;
	logic signed [31:0] coef, data;
	logic signed [33:0] scaled;
	logic [31:0]        sat;
	word8_t             res_q;

	assign coef = (k_q[3] ^ k_q[0]) ? s : c;
	assign data = k_q[0] ? $signed(b[k_q[2:1]]) : $signed(a[k_q[2:1]]);

	// upper row subtracts the second term, lower row adds both terms
	assign total  = k_s1[3] ? (acc_q + prod_s1) : (acc_q - prod_s1);
	assign scaled = total[63:30];
	assign sat = (scaled > 34'sd2147483647) ? 32'h7FFF_FFFF :
	             (scaled < -34'sd2147483648) ? 32'h8000_0000 : scaled[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			vld_s1 <= run_q;
			done_q <= vld_s1 && (k_s1 == 4'd15);
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 4'd1;
				if (k_q == 4'd15) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * data;
		k_s1    <= k_q;
		if (vld_s1) begin
			if (!k_s1[0]) acc_q <= prod_s1 + ROUND_HALF;
			else res_q <= {sat, res_q[7:1]};
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/core/time_phased_z_pose_rotator.sv =====
// ----------------------------------------------------------------------------
// time_phased_z_pose_rotator: time-phased rotation of a pose about Z
// Phase = rpm/60 * (offset + time) turns, cos/sin by a chain of CORDIC cells,
// rotation of the first two pose rows, timestamp order status.
//
//   channel  handshake             payload
//   -------  --------------------  -------------------------------------------
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (0 spin_rpm, 1 offset)
//   in       in_valid/in_stall     first_point, time_stamp, in_r0x.., in_ty
//   out      out_valid/out_stall   out_r00 .. out_ty, point_status
//
// One item at a time; from input acceptance to out_valid it passes the phase
// products, fold and reciprocal divide by 15, the CORDIC cell chain, the
// shared-multiplier rotation and the handoff. The input reopens with the
// handoff, so a new item is accepted only once the last one is handed off.
// Reset: registers to zero, previous time to -1.0 s, no item in flight.
// A held result does not block acceptance of the next item; a finished
// item waits in the rotator until the output register frees.
// ----------------------------------------------------------------------------
module time_phased_z_pose_rotator (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write transaction
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	// input transaction
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first_point,
	input  logic signed [31:0] time_stamp,
	input  logic signed [31:0] in_r00,
	input  logic signed [31:0] in_r01,
	input  logic signed [31:0] in_r02,
	input  logic signed [31:0] in_tx,
	input  logic signed [31:0] in_r10,
	input  logic signed [31:0] in_r11,
	input  logic signed [31:0] in_r12,
	input  logic signed [31:0] in_ty,
	// output transaction
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_r00,
	output logic signed [31:0] out_r01,
	output logic signed [31:0] out_r02,
	output logic signed [31:0] out_tx,
	output logic signed [31:0] out_r10,
	output logic signed [31:0] out_r11,
	output logic signed [31:0] out_r12,
	output logic signed [31:0] out_ty,
	output logic [1:0]         point_status
);
	import tpzr_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_PHASE, ST_CORDIC, ST_ROT, ST_HOLD} state_t;

	state_t             state_q;
	logic signed [31:0] spin_rpm_q;
	logic [31:0]        start_offset_q;
	logic [31:0]        prev_time_q;
	logic [1:0]         status_q, status_d;
	logic [31:0]        prev_eff;
	logic signed [33:0] sum_q;
	word4_t             a_q, b_q;
	logic               in_acc;
	logic               phase_start_q, cin_vld_q, rot_start_q, out_valid_q;
	logic               phase_done, rot_done;
	logic [31:0]        phase;
	logic [1:0]         quad_q, quad_d;
	logic [31:0]        resid;
	logic signed [33:0] z0_q;
	logic signed [31:0] c_q, s_q, c_d, s_d;
	word8_t             res, out_q;
	logic [1:0]         out_status_q;
	cordic_vec_t        chain [CORDIC_STEPS + 1];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;

	// timestamp ordering; a first point drops the history before the checks
	assign prev_eff = first_point ? MINUS_ONE_SEC : prev_time_q;
	always_comb begin
		if (time_stamp < 32'sd0) status_d = STATUS_NEG;
		else if (time_stamp < $signed(prev_eff)) status_d = STATUS_DEC;
		else status_d = STATUS_OK;
	end

	// nearest quarter turn and residual angle for the CORDIC
	assign quad_d = 2'((phase + 32'h2000_0000) >> 30);
	assign resid  = phase - {quad_d, 30'd0};

	// quadrant fold of the CORDIC result, clamped to unit range
	always_comb begin
		unique case (quad_q)
			2'd0: begin
				c_d = clamp_unit(chain[CORDIC_STEPS].x);
				s_d = clamp_unit(chain[CORDIC_STEPS].y);
			end
			2'd1: begin
				c_d = clamp_unit(-chain[CORDIC_STEPS].y);
				s_d = clamp_unit(chain[CORDIC_STEPS].x);
			end
			2'd2: begin
				c_d = clamp_unit(-chain[CORDIC_STEPS].x);
				s_d = clamp_unit(-chain[CORDIC_STEPS].y);
			end
			2'd3: begin
				c_d = clamp_unit(chain[CORDIC_STEPS].y);
				s_d = clamp_unit(-chain[CORDIC_STEPS].x);
			end
			default: begin
				c_d = '0;
				s_d = '0;
			end
		endcase
	end

	// control: sequencer, config registers, history, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			spin_rpm_q     <= '0;
			start_offset_q <= '0;
			prev_time_q    <= MINUS_ONE_SEC;
			phase_start_q  <= 1'b0;
			cin_vld_q      <= 1'b0;
			rot_start_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// one-cycle unit starts
			phase_start_q <= (state_q == ST_IDLE) && in_acc;
			cin_vld_q     <= (state_q == ST_PHASE) && phase_done;
			rot_start_q   <= (state_q == ST_CORDIC) && chain[CORDIC_STEPS].vld;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SPIN_RPM:     spin_rpm_q     <= cfg_data;
					REG_START_OFFSET: start_offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_HOLD && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (status_d == STATUS_OK) prev_time_q <= time_stamp;
						else if (first_point) prev_time_q <= MINUS_ONE_SEC;
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE:  if (phase_done) state_q <= ST_CORDIC;
				ST_CORDIC: if (chain[CORDIC_STEPS].vld) state_q <= ST_ROT;
				ST_ROT:    if (rot_done) state_q <= ST_HOLD;
				ST_HOLD:   if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q    <= $signed({2'b00, start_offset_q}) + 34'(time_stamp);
			status_q <= status_d;
			a_q      <= {in_tx, in_r02, in_r01, in_r00};
			b_q      <= {in_ty, in_r12, in_r11, in_r10};
		end
		if (phase_done) begin
			quad_q <= quad_d;
			z0_q   <= 34'($signed(resid));
		end
		if (state_q == ST_CORDIC && chain[CORDIC_STEPS].vld) begin
			c_q <= c_d;
			s_q <= s_d;
		end
		if (state_q == ST_HOLD && (!out_valid_q || !out_stall)) begin
			out_q        <= res;
			out_status_q <= status_q;
		end
	end

	tpzr_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (phase_start_q),
		.rpm    (spin_rpm_q),
		.sum    (sum_q),
		.done   (phase_done),
		.phase  (phase)
	);

	// CORDIC: row of rotation cells, one step each
	assign chain[0] = '{vld: cin_vld_q, x: INV_GAIN_Q30, y: 34'sd0, z: z0_q};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		tpzr_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (5'(i)),
			.din    (chain[i]),
			.dout   (chain[i + 1])
		);
	end

	tpzr_rotate u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start_q),
		.c      (c_q),
		.s      (s_q),
		.a      (a_q),
		.b      (b_q),
		.done   (rot_done),
		.res    (res)
	);

	assign out_valid    = out_valid_q;
	assign out_r00      = out_q[0];
	assign out_r01      = out_q[1];
	assign out_r02      = out_q[2];
	assign out_tx       = out_q[3];
	assign out_r10      = out_q[4];
	assign out_r11      = out_q[5];
	assign out_r12      = out_q[6];
	assign out_ty       = out_q[7];
	assign point_status = out_status_q;

	// an accepted item closes the input until it is handed off
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input open after accepting a transaction");

	// the cell chain only delivers while the sequencer waits for it
	a_chain_state: assert property (@(posedge clk) disable iff (!arst_n)
		chain[CORDIC_STEPS].vld |-> state_q == ST_CORDIC)
		else $error("CORDIC result outside its wait state");

	// unit completions never overlap
	a_done_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({phase_done, chain[CORDIC_STEPS].vld, rot_done}))
		else $error("overlapping unit completions");

	// status code is one of the three defined values
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_status != 2'd3)
		else $error("undefined point status");

endmodule

// ===== tb/tpzr_pose_checker.sv =====
// ----------------------------------------------------------------------------
// tpzr_pose_checker: result predictor and comparator
// Watches the cfg, in and out channels of the time-phased Z pose rotator. It
// predicts each rotated pose and status from its own copy of the registers and
// timestamp history, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module tpzr_pose_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               first_point,
	input  logic signed [31:0] time_stamp,
	input  logic signed [31:0] in_r00,
	input  logic signed [31:0] in_r01,
	input  logic signed [31:0] in_r02,
	input  logic signed [31:0] in_tx,
	input  logic signed [31:0] in_r10,
	input  logic signed [31:0] in_r11,
	input  logic signed [31:0] in_r12,
	input  logic signed [31:0] in_ty,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_r00,
	input  logic signed [31:0] out_r01,
	input  logic signed [31:0] out_r02,
	input  logic signed [31:0] out_tx,
	input  logic signed [31:0] out_r10,
	input  logic signed [31:0] out_r11,
	input  logic signed [31:0] out_r12,
	input  logic signed [31:0] out_ty,
	input  logic [1:0]         point_status,
	output int                 errors,
	output int                 pending
);
	import tpzr_pkg::*;

	typedef struct packed {
		word8_t     w;
		logic [1:0] status;
	} pose_t;

	// arctangent of 2^-i, 2^-32 turn units
	localparam longint ATAN_TURNS [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};
	localparam logic signed [127:0] TURN_MOD = 128'sd257698037760; // 60 * 2^32

	localparam string FIELD_NAME [8] = '{
		"out_r00", "out_r01", "out_r02", "out_tx",
		"out_r10", "out_r11", "out_r12", "out_ty"
	};

	logic signed [31:0] rpm_q;
	logic [31:0]        offset_q;
	logic signed [31:0] last_time;
	pose_t              pose_q [$];

	// binary angle of rpm/60 * (offset + ts), modulo one turn
	function automatic logic [31:0] spin_angle(input logic signed [31:0] ts);
		logic signed [127:0] sum, prod, r;
		sum = $signed({96'd0, offset_q}) + ts;
		prod = sum * rpm_q;
		r = prod % TURN_MOD;
		if (r < 0) r = r + TURN_MOD;
		return 32'(r / 60);
	endfunction

	function automatic void unit_vector(input logic [31:0] ang, output longint c,
			output longint s);
		logic [31:0] tmp, zw;
		logic [1:0]  q;
		longint      x, y, z, dx, dy, t;
		tmp = ang + 32'h2000_0000;
		q = tmp[31:30];
		zw = ang - {q, 30'd0};
		z = longint'($signed(zw));
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURNS[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURNS[i];
			end
		end
		case (q)
			2'd1: begin t = x; x = -y; y = t; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		c = (x > 64'sd1073741824) ? 64'sd1073741824 : (x < -64'sd1073741824) ? -64'sd1073741824 : x;
		s = (y > 64'sd1073741824) ? 64'sd1073741824 : (y < -64'sd1073741824) ? -64'sd1073741824 : y;
	endfunction

	// rounded Q30 product sum, saturated to 32 bits
	function automatic logic [31:0] mix_round(input longint p);
		longint v;
		v = (p + 64'sd536870912) >>> 30;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// predicted result of one point; advances the timestamp history
	function automatic pose_t rotated_pose(input logic fp, input logic signed [31:0] ts,
			input word8_t pin);
		pose_t  res;
		longint c, s, a, b;
		if (fp) last_time = MINUS_ONE_SEC;
		if (ts < 0) res.status = STATUS_NEG;
		else if (ts < last_time) res.status = STATUS_DEC;
		else res.status = STATUS_OK;
		if (res.status == STATUS_OK) last_time = ts;
		unit_vector(spin_angle(ts), c, s);
		for (int j = 0; j < 4; j++) begin
			a = longint'($signed(pin[j]));
			b = longint'($signed(pin[4 + j]));
			res.w[j] = mix_round(c * a - s * b);
			res.w[4 + j] = mix_round(s * a + c * b);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word8_t pin, pout;
		pose_t  got, want;
		if (!arst_n) begin
			rpm_q <= '0;
			offset_q <= '0;
			last_time = MINUS_ONE_SEC;
			pose_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SPIN_RPM) rpm_q <= cfg_data;
				else offset_q <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				pin = {in_ty, in_r12, in_r11, in_r10, in_tx, in_r02, in_r01, in_r00};
				pose_q = {pose_q, rotated_pose(first_point, time_stamp, pin)};
			end
			if (out_valid && !out_stall) begin
				pout = {out_ty, out_r12, out_r11, out_r10, out_tx, out_r02, out_r01, out_r00};
				if (pose_q.size() == 0) begin
					$error("result transaction with no point outstanding");
					errors <= errors + 1;
				end else begin
					want = pose_q.pop_front();
					got.w = pout;
					got.status = point_status;
					if (got != want) errors <= errors + 1;
					for (int j = 0; j < 8; j++)
						if (got.w[j] !== want.w[j])
							$error("%s: expected %0d, got %0d", FIELD_NAME[j],
								$signed(want.w[j]), $signed(got.w[j]));
					if (got.status !== want.status)
						$error("point_status: expected %0d, got %0d", want.status,
							got.status);
				end
			end
			pending <= pose_q.size();
		end
	end

endmodule

// ===== tb/time_phased_z_pose_rotator_test.sv =====
// ----------------------------------------------------------------------------
// time_phased_z_pose_rotator_test: top-level testbench
// Drives register writes and pose points into the rotator under random source
// and sink gaps, a long sink hold-off and drain pauses. Checking is done by
// tpzr_pose_checker; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module time_phased_z_pose_rotator_test;
	import tpzr_pkg::*;

	localparam int     ITEMS_PER_PHASE = 450;
	localparam longint CYCLE_LIMIT     = 3_000_000;
	localparam int     SETTLE_CYCLES   = 120;     // above the item latency

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = 1'b0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               first_point = 1'b0;
	logic signed [31:0] time_stamp = '0;
	logic signed [31:0] in_r00 = '0, in_r01 = '0, in_r02 = '0, in_tx = '0;
	logic signed [31:0] in_r10 = '0, in_r11 = '0, in_r12 = '0, in_ty = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_r00, out_r01, out_r02, out_tx;
	logic signed [31:0] out_r10, out_r11, out_r12, out_ty;
	logic [1:0]         point_status;

	int     fail_count;
	int     pending;
	int     send_idle_pct = 0;   // chance per cycle that the source idles
	int     sink_stall_pct = 0;  // chance per cycle that the sink stalls
	int     hold_request = 0;    // long sink hold-off, picked up by the sink process
	longint cycle_count = 0;

	time_phased_z_pose_rotator i_dut (.*);

	tpzr_pose_checker i_check (.*, .errors(fail_count), .pending(pending));

	initial begin
		forever #10 clk = ~clk;
	end

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sink: random stall, or a counted hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < sink_stall_pct);
			end
		end
	end

	// one register write transaction
	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every predicted result has been seen, then let the block settle
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one point transaction; in_valid stays high into the next call unless idling
	task automatic send_point(input logic fp, input logic signed [31:0] ts,
			input word8_t p);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		first_point <= fp;
		time_stamp <= ts;
		{in_ty, in_r12, in_r11, in_r10, in_tx, in_r02, in_r01, in_r00} <= p;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// pose entry: full range, edge values, or near the unit range
	function automatic logic [31:0] pose_word();
		logic [31:0] edges [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFF};
		case ($urandom_range(3))
			0: return $urandom;
			1: return edges[$urandom_range(5)];
			default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
		endcase
	endfunction

	function automatic word8_t random_pose();
		word8_t p;
		for (int j = 0; j < 8; j++) p[j] = pose_word();
		return p;
	endfunction

	// identity-like pose with given translations
	function automatic word8_t unit_pose(input logic [31:0] tx, input logic [31:0] ty);
		return {ty, 32'h0, 32'h4000_0000, 32'h0, tx, 32'h0, 32'h0, 32'h4000_0000};
	endfunction

	initial begin
		logic [31:0] rpm_set [4];
		logic [31:0] off_set [4];
		longint      traj_time;
		logic        fp;
		logic [31:0] ts;
		int          pick;

		// quarter turn per second first, then the extremes, then a random setting
		rpm_set = '{32'd15 << 16, 32'h7FFF_FFFF, 32'h8000_0000, $urandom};
		off_set = '{32'h0000_4000, 32'hFFFF_FFFF, 32'h0, $urandom};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			// gap profile: sink busy / source dense, swapped, none, then the first again
			case (ph)
				0, 3: begin send_idle_pct = 15; sink_stall_pct = 58; end
				1: begin send_idle_pct = 58; sink_stall_pct = 15; end
				default: begin send_idle_pct = 0; sink_stall_pct = 0; end
			endcase
			stop_sending();
			drain();
			write_reg(REG_SPIN_RPM, rpm_set[ph]);
			write_reg(REG_START_OFFSET, off_set[ph]);

			if (ph == 0) begin
				// start of trajectory and quarter-turn steps
				send_point(1'b1, 32'sd0, unit_pose(32'h0001_0000, 32'h0));
				send_point(1'b0, 32'sh0000_2000, unit_pose(32'h0001_0000, 32'h0002_0000));
				send_point(1'b0, 32'sh0001_0000, unit_pose(32'h0001_0000, 32'h0));
				send_point(1'b0, 32'sh0002_0000, unit_pose(32'h0001_0000, 32'h0));
				send_point(1'b0, 32'sh0003_0000, unit_pose(32'h0001_0000, 32'h0));
				send_point(1'b0, 32'sh0003_8000, unit_pose(32'h0001_0000, 32'h0));
				// negative timestamps: most negative and minus one LSB
				send_point(1'b0, 32'sh8000_0000, unit_pose(32'h0, 32'h0));
				send_point(1'b0, -32'sd1, unit_pose(32'h0, 32'h0));
				// timestamp earlier than the last good point, then a history reset
				send_point(1'b0, 32'sd100, unit_pose(32'h0, 32'h0));
				send_point(1'b1, 32'sd100, unit_pose(32'h0, 32'h0));
				send_point(1'b0, 32'sh7FFF_FFFF, unit_pose(32'h7FFF_FFFF, 32'h8000_0000));
				// saturating entries and translations
				send_point(1'b1, 32'sh0000_6000, {8{32'h7FFF_FFFF}});
				send_point(1'b0, 32'sh0000_7000, {8{32'h8000_0000}});
				send_point(1'b0, 32'sh0000_A000,
					{4{32'h7FFF_FFFF, 32'h8000_0000}});
				send_point(1'b0, 32'sh0000_A000,
					{4{32'h8000_0000, 32'h7FFF_FFFF}});
				send_point(1'b0, 32'sh0000_B000, {8{32'hFFFF_FFFF}});
				send_point(1'b0, 32'sh0000_B000, {8{32'h0}});
			end

			if (ph == 3) hold_request = 400;   // fill the block and back up the input

			traj_time = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// source pause until every result is back
				if (n == ITEMS_PER_PHASE / 2) begin
					stop_sending();
					while (pending != 0) @(posedge clk);
				end
				pick = $urandom_range(99);
				fp = 1'b0;
				if (n == 0 || pick < 6) begin
					// new trajectory
					fp = 1'b1;
					traj_time = $urandom_range(32'h0010_0000);
				end else if (pick < 88) begin
					traj_time += $urandom_range(70000);
				end else if (pick < 93) begin
					traj_time -= $urandom_range(70000);   // goes backwards
				end else begin
					traj_time = longint'($signed(32'($urandom)));   // any timestamp
					fp = $urandom_range(1);
				end
				if (traj_time > 64'sd2147483647) traj_time = 64'sd2147483647;
				if (traj_time < -64'sd2147483648) traj_time = -64'sd2147483648;
				ts = traj_time[31:0];
				send_point(fp, ts, random_pose());
			end
		end

		stop_sending();
		drain();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
